// ===== sv/fiur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiur_pkg
// Shared types and constants for the framed image update receiver.
// ----------------------------------------------------------------------------
package fiur_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_HEADER     = 3'd1,
        PH_ERASING    = 3'd2,
        PH_RECEIVING  = 3'd3,
        PH_VERIFYING  = 3'd4,
        PH_COMMITTING = 3'd5,
        PH_DONE       = 3'd6,
        PH_ERROR      = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_FLASH = 2'd2,
        MODE_ABORT = 2'd3
    } t_mode;

    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_ACK  = 2'd1;
    localparam logic [1:0] RESP_NAK  = 2'd2;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_TIMEOUT  = 4'd1;
    localparam logic [3:0] ERR_TOO_BIG  = 4'd2;
    localparam logic [3:0] ERR_ERASE    = 4'd3;
    localparam logic [3:0] ERR_SEQ      = 4'd4;
    localparam logic [3:0] ERR_CHUNK    = 4'd5;
    localparam logic [3:0] ERR_WRITE    = 4'd6;
    localparam logic [3:0] ERR_IMAGE    = 4'd7;
    localparam logic [3:0] ERR_META     = 4'd8;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_ERASE = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_META  = 3'd3;
    localparam logic [2:0] CMD_RESET = 3'd4;

    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_A_BASE  = 3'd1;
    localparam logic [2:0] REG_A_SIZE  = 3'd2;
    localparam logic [2:0] REG_B_BASE  = 3'd3;
    localparam logic [2:0] REG_B_SIZE  = 3'd4;
    localparam logic [2:0] REG_TIMEOUT = 3'd5;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;
    localparam logic [7:0]  BANK_A_CODE = 8'hAA;
    localparam logic [7:0]  BANK_B_CODE = 8'h55;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic        flash_ok;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  response;
        logic [3:0]  error_code;
        logic [2:0]  flash_cmd;
        logic [31:0] flash_addr;
        logic [31:0] flash_word;
        logic [7:0]  bank_code;
        logic        last;
        logic [2:0]  fsm_state;
        logic [3:0]  latched_error;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

// ===== sv/fiur_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiur_in_if / fiur_out_if / fiur_cfg_if
// Valid/ready channels of the receiver.
// ----------------------------------------------------------------------------
interface fiur_in_if;
    logic valid;
    logic ready;
    fiur_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fiur_out_if;
    logic valid;
    logic ready;
    fiur_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fiur_cfg_if;
    logic valid;
    logic ready;
    fiur_pkg::t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/fiur_page_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiur_page_ram
// Page buffer: byte writes, registered word reads.
// ----------------------------------------------------------------------------
module fiur_page_ram #(
    parameter int WORDS = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wlane,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [7:0] r_mem0 [WORDS];
    logic [7:0] r_mem1 [WORDS];
    logic [7:0] r_mem2 [WORDS];
    logic [7:0] r_mem3 [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we && i_wlane == 2'd0) r_mem0[i_waddr] <= i_wdata;
        if (i_we && i_wlane == 2'd1) r_mem1[i_waddr] <= i_wdata;
        if (i_we && i_wlane == 2'd2) r_mem2[i_waddr] <= i_wdata;
        if (i_we && i_wlane == 2'd3) r_mem3[i_waddr] <= i_wdata;
        o_rdata <= {r_mem3[i_raddr], r_mem2[i_raddr], r_mem1[i_raddr], r_mem0[i_raddr]};
    end
endmodule

// ===== sv/framed_image_update_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_image_update_receiver_core
// Receives a framed firmware image and drives bank erase, page writes and
// metadata commit.
// ----------------------------------------------------------------------------
// Each transaction is handled one at a time. A byte that completes a frame
// with the expected sequence number and a good chunk CRC emits PAGE_BYTES/4
// write-word results as the output takes them, streamed out of the page
// memory through its registered read port; a failed check emits a NAK. A
// flash result emits up to two results. The next input is accepted once all
// results of the current one have been handed to the output register.
module framed_image_update_receiver_core #(
    parameter int PAGE_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fiur_in_if.sink       in_ch,
    fiur_out_if.source    out_ch,
    fiur_cfg_if.sink      cfg_ch
);
    import fiur_pkg::*;

    localparam int WORDS = PAGE_BYTES / 4;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FRAME = PAGE_BYTES + 8;
    localparam int CW    = $clog2(FRAME + 1);
    localparam int PSH   = $clog2(PAGE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_EMIT, S_WRITES, S_EMIT2
    } t_seq;

    t_seq   r_seq;
    t_phase r_phase;
    logic        r_await;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_shift, r_size, r_icrc, r_total, r_nseq, r_rseq, r_rcrc, r_waddr;
    logic [31:0] r_run, r_chk, r_cand, r_elapsed;
    logic        r_bank;
    logic [3:0]  r_err;
    logic [31:0] r_magic, r_abase, r_asize, r_bbase, r_bsize;
    logic [15:0] r_tmo;
    t_in_item    r_in;
    t_out_item   r_q1, r_q2;
    logic        r_has2;
    logic [AW:0] r_widx;
    logic        r_rd_ok;
    logic        r_ovalid;
    t_out_item   r_out;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [CW-1:0] pidx;

    assign pidx = r_cnt - CW'(8);

    fiur_page_ram #(.WORDS(WORDS), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(pidx[PSH-1:2]),
        .i_wlane(pidx[1:0]),
        .i_wdata(r_in.rx_byte),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic out_free;
    assign out_free = !r_ovalid || out_ch.ready;
    assign in_ch.ready = (r_seq == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data = r_out;
    assign ram_we = (r_seq == S_EXEC) && r_in.mode == MODE_BYTE && !r_await
                    && r_phase == PH_RECEIVING && r_cnt >= CW'(8) && r_cnt < CW'(FRAME);
    assign ram_raddr = r_widx[AW-1:0];

    function automatic t_out_item mk(input logic [1:0] rs, input logic [3:0] ec,
                                     input logic [2:0] cm, input logic [31:0] ad,
                                     input logic [31:0] wd, input logic [7:0] bc,
                                     input t_phase ph, input logic [3:0] le);
        t_out_item o;
        o.response = rs; o.error_code = ec; o.flash_cmd = cm; o.flash_addr = ad;
        o.flash_word = wd; o.bank_code = bc; o.last = 1'b0; o.fsm_state = ph;
        o.latched_error = le;
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0; r_abase <= '0; r_asize <= '0; r_bbase <= '0; r_bsize <= '0;
            r_tmo <= 16'd1000;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.data.index)
                REG_MAGIC:   r_magic <= cfg_ch.data.data;
                REG_A_BASE:  r_abase <= cfg_ch.data.data;
                REG_A_SIZE:  r_asize <= cfg_ch.data.data;
                REG_B_BASE:  r_bbase <= cfg_ch.data.data;
                REG_B_SIZE:  r_bsize <= cfg_ch.data.data;
                REG_TIMEOUT: r_tmo <= cfg_ch.data.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] ws, maxsz, base, cc, cd, nn, el;
        logic [CW-1:0] c;
        t_out_item o;
        t_seq n_seq;
        logic n_ovalid;
        logic n_await;
        if (!i_rst_n) begin
            r_seq <= S_IDLE; r_phase <= PH_IDLE; r_await <= 1'b0; r_cnt <= '0;
            r_shift <= '0; r_size <= '0; r_icrc <= '0; r_total <= '0; r_nseq <= '0;
            r_rseq <= '0; r_rcrc <= '0; r_waddr <= '0; r_run <= ALL_ONES;
            r_chk <= ALL_ONES; r_cand <= ALL_ONES; r_elapsed <= '0; r_bank <= 1'b0;
            r_err <= '0; r_ovalid <= 1'b0; r_has2 <= 1'b0; r_widx <= '0; r_rd_ok <= 1'b0;
        end else begin
            n_seq = r_seq;
            n_ovalid = r_ovalid && !(out_ch.valid && out_ch.ready);
            n_await = r_await;
            unique case (r_seq)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_in <= in_ch.data;
                        n_seq = S_EXEC;
                    end
                end
                S_EXEC: begin
                    n_seq = S_IDLE;
                    unique case (t_mode'(r_in.mode))
                        MODE_BYTE: if (!r_await) begin
                            ws = {r_in.rx_byte, r_shift[31:8]};
                            r_shift <= ws;
                            if (r_phase == PH_IDLE) begin
                                if (r_cnt >= CW'(3)) begin
                                    r_cnt <= '0;
                                    if (ws == r_magic) begin
                                        r_phase <= PH_HEADER; r_elapsed <= '0;
                                        r_q1 <= mk(RESP_ACK, ERR_NONE, CMD_NONE, '0, '0, '0,
                                                   PH_HEADER, r_err);
                                        n_seq = S_EMIT;
                                    end
                                end else r_cnt <= r_cnt + CW'(1);
                            end else if (r_phase == PH_HEADER) begin
                                c = r_cnt + CW'(1);
                                r_cnt <= (c >= CW'(12)) ? '0 : c;
                                if (c == CW'(4)) r_size <= ws;
                                else if (c == CW'(8)) r_icrc <= ws;
                                else if (c >= CW'(12)) begin
                                    r_bank <= (ws != 0);
                                    maxsz = (ws != 0) ? r_bsize : r_asize;
                                    base = (ws != 0) ? r_bbase : r_abase;
                                    if (r_size == 0 || r_size > maxsz) begin
                                        r_err <= ERR_TOO_BIG; r_phase <= PH_ERROR;
                                        r_q1 <= mk(RESP_NAK, ERR_TOO_BIG, CMD_NONE, '0, '0,
                                                   '0, PH_ERROR, ERR_TOO_BIG);
                                    end else begin
                                        r_total <= (r_size >> PSH) +
                                            32'(r_size[PSH-1:0] != 0);
                                        r_phase <= PH_ERASING; n_await = 1'b1;
                                        r_q1 <= mk(RESP_NONE, ERR_NONE, CMD_ERASE, base, '0,
                                                   '0, PH_ERASING, r_err);
                                    end
                                    n_seq = S_EMIT;
                                end
                            end else if (r_phase == PH_RECEIVING) begin
                                cc = r_chk; cd = r_cand;
                                if (r_cnt == CW'(8)) begin cc = ALL_ONES; cd = r_run; end
                                if (r_cnt >= CW'(8) && r_cnt < CW'(FRAME)) begin
                                    r_chk <= crc_byte(cc, r_in.rx_byte);
                                    r_cand <= crc_byte(cd, r_in.rx_byte);
                                end
                                c = r_cnt + CW'(1);
                                r_cnt <= (c >= CW'(FRAME)) ? '0 : c;
                                if (c == CW'(4)) r_rseq <= ws;
                                else if (c == CW'(8)) r_rcrc <= ws;
                                else if (c >= CW'(FRAME)) begin
                                    if (r_rseq != r_nseq) begin
                                        r_err <= ERR_SEQ;
                                        r_q1 <= mk(RESP_NAK, ERR_SEQ, CMD_NONE, '0, '0, '0,
                                                   PH_RECEIVING, ERR_SEQ);
                                        n_seq = S_EMIT;
                                    end else if ((crc_byte(cc, r_in.rx_byte) ^ ALL_ONES)
                                                 != r_rcrc) begin
                                        r_err <= ERR_CHUNK;
                                        r_q1 <= mk(RESP_NAK, ERR_CHUNK, CMD_NONE, '0, '0, '0,
                                                   PH_RECEIVING, ERR_CHUNK);
                                        n_seq = S_EMIT;
                                    end else begin
                                        n_await = 1'b1; r_widx <= '0; r_rd_ok <= 1'b0;
                                        n_seq = S_WRITES;
                                    end
                                end
                            end
                        end
                        MODE_TICK: begin
                            if (!r_await && (r_phase == PH_HEADER ||
                                             r_phase == PH_RECEIVING)) begin
                                el = (r_elapsed != ALL_ONES) ? r_elapsed + 1 : r_elapsed;
                                r_elapsed <= el;
                                if (el > {16'd0, r_tmo}) begin
                                    r_err <= ERR_TIMEOUT; r_phase <= PH_ERROR;
                                    r_q1 <= mk(RESP_NAK, ERR_TIMEOUT, CMD_NONE, '0, '0, '0,
                                               PH_ERROR, ERR_TIMEOUT);
                                    n_seq = S_EMIT;
                                end
                            end
                        end
                        MODE_FLASH: if (r_await) begin
                            n_await = 1'b0;
                            n_seq = S_EMIT;
                            if (r_phase == PH_ERASING) begin
                                if (!r_in.flash_ok) begin
                                    r_err <= ERR_ERASE; r_phase <= PH_ERROR;
                                    r_q1 <= mk(RESP_NAK, ERR_ERASE, CMD_NONE, '0, '0, '0,
                                               PH_ERROR, ERR_ERASE);
                                end else begin
                                    r_nseq <= '0; r_waddr <= r_bank ? r_bbase : r_abase;
                                    r_run <= ALL_ONES; r_elapsed <= '0; r_cnt <= '0;
                                    r_phase <= PH_RECEIVING;
                                    r_q1 <= mk(RESP_ACK, ERR_NONE, CMD_NONE, '0, '0, '0,
                                               PH_RECEIVING, r_err);
                                end
                            end else if (r_phase == PH_RECEIVING) begin
                                if (!r_in.flash_ok) begin
                                    r_err <= ERR_WRITE; r_phase <= PH_ERROR;
                                    r_q1 <= mk(RESP_NAK, ERR_WRITE, CMD_NONE, '0, '0, '0,
                                               PH_ERROR, ERR_WRITE);
                                end else begin
                                    nn = r_nseq + 1;
                                    r_run <= r_cand; r_waddr <= r_waddr + PAGE_BYTES;
                                    r_nseq <= nn; r_elapsed <= '0;
                                    if (nn >= r_total) begin
                                        r_q1 <= mk(RESP_ACK, ERR_NONE, CMD_NONE, '0, '0, '0,
                                                   PH_VERIFYING, r_err);
                                        r_has2 <= 1'b1;
                                        if ((r_cand ^ ALL_ONES) != r_icrc) begin
                                            r_err <= ERR_IMAGE; r_phase <= PH_ERROR;
                                            r_q2 <= mk(RESP_NAK, ERR_IMAGE, CMD_NONE, '0, '0,
                                                       '0, PH_ERROR, ERR_IMAGE);
                                        end else begin
                                            r_phase <= PH_COMMITTING; n_await = 1'b1;
                                            r_q2 <= mk(RESP_NONE, ERR_NONE, CMD_META, '0,
                                                       r_icrc,
                                                       r_bank ? BANK_B_CODE : BANK_A_CODE,
                                                       PH_COMMITTING, r_err);
                                        end
                                    end else begin
                                        r_q1 <= mk(RESP_ACK, ERR_NONE, CMD_NONE, '0, '0, '0,
                                                   PH_RECEIVING, r_err);
                                    end
                                end
                            end else if (r_phase == PH_COMMITTING) begin
                                if (!r_in.flash_ok) begin
                                    r_err <= ERR_META; r_phase <= PH_ERROR;
                                    r_q1 <= mk(RESP_NAK, ERR_META, CMD_NONE, '0, '0, '0,
                                               PH_ERROR, ERR_META);
                                end else begin
                                    r_phase <= PH_DONE; r_has2 <= 1'b1;
                                    r_q1 <= mk(RESP_ACK, ERR_NONE, CMD_NONE, '0, '0, '0,
                                               PH_DONE, r_err);
                                    r_q2 <= mk(RESP_NONE, ERR_NONE, CMD_RESET, '0, '0, '0,
                                               PH_DONE, r_err);
                                end
                            end else n_seq = S_IDLE;
                        end
                        MODE_ABORT: begin
                            r_phase <= PH_IDLE; r_err <= '0; n_await = 1'b0;
                            r_cnt <= '0; r_shift <= '0;
                        end
                        default: ;
                    endcase
                end
                S_EMIT: begin
                    if (out_free) begin
                        o = r_q1; o.last = !r_has2;
                        r_out <= o; n_ovalid = 1'b1;
                        r_has2 <= 1'b0;
                        n_seq = r_has2 ? S_EMIT2 : S_IDLE;
                    end
                end
                S_EMIT2: begin
                    if (out_free) begin
                        o = r_q2; o.last = 1'b1;
                        r_out <= o; n_ovalid = 1'b1;
                        n_seq = S_IDLE;
                    end
                end
                S_WRITES: begin
                    if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else if (out_free) begin
                        o = mk(RESP_NONE, ERR_NONE, CMD_WRITE,
                               r_waddr + 32'({r_widx, 2'b00}), ram_rdata, '0, r_phase,
                               r_err);
                        o.last = (r_widx == (AW+1)'(WORDS - 1));
                        r_out <= o; n_ovalid = 1'b1;
                        r_rd_ok <= 1'b0;
                        if (o.last) n_seq = S_IDLE;
                        else r_widx <= r_widx + 1'b1;
                    end
                end
                default: n_seq = S_IDLE;
            endcase
            r_seq <= n_seq;
            r_ovalid <= n_ovalid;
            r_await <= n_await;
        end
    end
endmodule
